// ===== rtl/lsw_pkg.sv =====
// ----------------------------------------------------------------------------
// lsw_pkg
// Shared types and constants for the Witt necklace length block.
// ----------------------------------------------------------------------------
package lsw_pkg;

  localparam int unsigned DimW = 64;
  localparam int unsigned DegW = 7;

  typedef logic [DimW-1:0] word_t;
  typedef logic [DegW-1:0] deg_t;

  // Datapath operations
  localparam logic [3:0] OP_NOP     = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;  // latch query
  localparam logic [3:0] OP_LVL     = 4'd2;  // start level: acc=0, d=1
  localparam logic [3:0] OP_DIVCHK  = 4'd3;  // start i mod d
  localparam logic [3:0] OP_POWINIT = 4'd4;  // pacc=1, base=dim, e=d
  localparam logic [3:0] OP_MULT    = 4'd5;  // pacc=product
  localparam logic [3:0] OP_SQR     = 4'd6;  // base=product, e>>=1
  localparam logic [3:0] OP_MOBINIT = 4'd7;  // qn=i, q=d, n=0, sign=+
  localparam logic [3:0] OP_MOBSTEP = 4'd8;  // one trial step
  localparam logic [3:0] OP_ADD     = 4'd9;  // add signed term
  localparam logic [3:0] OP_NEXTD   = 4'd10;
  localparam logic [3:0] OP_QSTART  = 4'd11; // start acc / i
  localparam logic [3:0] OP_QSTEP   = 4'd12;
  localparam logic [3:0] OP_QDONE   = 4'd13; // total += quotient, i++
  localparam logic [3:0] OP_MULST   = 4'd14; // start pacc*base
  localparam logic [3:0] OP_SQRST   = 4'd15; // start base*base

  typedef struct packed {
    logic [3:0] op;
  } lsw_cmd_t;

  typedef struct packed {
    logic       zero_in;   // dim or deg zero
    logic       lvl_done;  // i > deg
    logic       d_done;    // d > i
    logic       div_busy;
    logic       divides;   // i mod d == 0
    logic       e_zero;
    logic       e_odd;
    logic       mul_busy;  // product in progress
    logic       mul_ovf;
    logic       sqr_ovf;
    logic       mob_busy;  // trial loop continues
    logic       add_ovf;
    logic       q_busy;
  } lsw_sts_t;

endpackage

// ===== rtl/lsw_if.sv =====
// ----------------------------------------------------------------------------
// lsw_in_if / lsw_out_if
// Valid-ready channels for queries and results.
// ----------------------------------------------------------------------------
interface lsw_in_if;
  import lsw_pkg::*;
  logic  valid;
  logic  ready;
  word_t dimension;
  deg_t  depth_level;
  modport source (output valid, dimension, depth_level, input ready);
  modport sink (input valid, dimension, depth_level, output ready);
endinterface

interface lsw_out_if;
  import lsw_pkg::*;
  logic  valid;
  logic  ready;
  word_t length;
  logic  overflowed;
  modport source (output valid, length, overflowed, input ready);
  modport sink (input valid, length, overflowed, output ready);
endinterface

// ===== rtl/lsw_datapath.sv =====
// ----------------------------------------------------------------------------
// lsw_datapath
// Registers and arithmetic: power, Mobius trial division, level sum, divide.
// ----------------------------------------------------------------------------
module lsw_datapath
  import lsw_pkg::*;
#(
  parameter int unsigned MAX_DEGREE = 64
) (
  input  logic     clk,
  input  lsw_cmd_t cmd,
  input  word_t    dimension,
  input  deg_t     depth_level,
  output lsw_sts_t sts,
  output word_t    total
);

  localparam int unsigned IW = DegW;

  word_t         dim_r;
  logic [IW-1:0] deg_r, i_r, d_r;
  logic [IW-1:0] rem_r;              // repeated-subtract i mod d
  word_t         pacc_r, base_r;
  logic [IW-1:0] e_r;
  logic [IW-1:0] n_r, q_r;
  logic [IW-1:0] qn_r;               // n mod q remainder scan
  logic [IW-1:0] qcnt_r;             // quotient of n by q
  logic [1:0]    mph_r;              // Mobius phase
  logic          sign_r, mzero_r;
  logic signed [DimW-1:0] acc_r;
  word_t         total_r;
  // restoring signed divide of acc by i
  logic [DimW-1:0] qq_r;
  logic [IW:0]     qrem_r;
  logic [6:0]      qc_r;
  logic            qneg_r;
  // low 64 bits of a product from three 32x32 partial products
  logic [1:0]    mcnt_r;
  logic          msel_r;
  word_t         mprod_r;
  word_t         mop_a;
  logic [31:0]   mul_x, mul_y;
  word_t         mprod_w;

  logic signed [DimW-1:0] term;
  logic [IW:0] qtry;

  assign mop_a   = msel_r ? base_r : pacc_r;
  assign mul_x   = (mcnt_r == 2'd2) ? mop_a[63:32] : mop_a[31:0];
  assign mul_y   = (mcnt_r == 2'd1) ? base_r[63:32] : base_r[31:0];
  assign mprod_w = word_t'(mul_x) * word_t'(mul_y);
  assign qtry  = {qrem_r[IW-1:0], qq_r[DimW-1]} - {1'b0, i_r};

  always_comb begin
    if (mzero_r) term = '0;
    else if (sign_r) term = $signed(pacc_r);
    else term = $signed(word_t'(0) - pacc_r);
  end

  logic signed [DimW:0] sum_w;
  assign sum_w = {acc_r[DimW-1], acc_r} + {term[DimW-1], term};

  always_ff @(posedge clk) begin
    if (cmd.op == OP_MULST || cmd.op == OP_SQRST) begin
      msel_r <= cmd.op == OP_SQRST;
      mcnt_r <= '0;
    end else if (mcnt_r != 2'd3) begin
      case (mcnt_r)
        2'd0: mprod_r <= mprod_w;
        default: mprod_r[63:32] <= mprod_r[63:32] + mprod_w[31:0];
      endcase
      mcnt_r <= mcnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        dim_r   <= dimension;
        deg_r   <= (depth_level > IW'(MAX_DEGREE)) ? IW'(MAX_DEGREE) : depth_level;
        i_r     <= IW'(1);
        total_r <= '0;
      end
      OP_LVL: begin
        acc_r <= '0;
        d_r   <= IW'(1);
      end
      OP_DIVCHK: rem_r <= i_r;
      OP_POWINIT: begin
        if (rem_r >= d_r) rem_r <= rem_r - d_r;
        else begin
          pacc_r <= word_t'(1);
          base_r <= dim_r;
          e_r    <= d_r;
        end
      end
      OP_MULT: pacc_r <= mprod_r;
      OP_SQR: begin
        base_r <= mprod_r;
        e_r    <= e_r >> 1;
      end
      OP_MOBINIT: begin
        n_r     <= '0;
        qn_r    <= i_r;   // compute n = i/d by subtraction
        q_r     <= d_r;
        qcnt_r  <= '0;
        mph_r   <= 2'd0;
        sign_r  <= 1'b1;
        mzero_r <= 1'b0;
      end
      OP_MOBSTEP: begin
        case (mph_r)
          2'd0: begin   // i/d
            if (qn_r >= q_r) begin
              qn_r   <= qn_r - q_r;
              qcnt_r <= qcnt_r + IW'(1);
            end else begin
              n_r    <= qcnt_r;
              q_r    <= IW'(2);
              qn_r   <= qcnt_r;
              qcnt_r <= '0;
              mph_r  <= 2'd1;
            end
          end
          2'd1: begin   // n mod q, n / q
            if (qn_r >= q_r) begin
              qn_r   <= qn_r - q_r;
              qcnt_r <= qcnt_r + IW'(1);
            end else if (qn_r == '0) begin
              n_r    <= qcnt_r;
              qn_r   <= qcnt_r;
              qcnt_r <= '0;
              mph_r  <= 2'd2;
            end else begin
              q_r    <= q_r + IW'(1);
              qn_r   <= n_r;
              qcnt_r <= '0;
            end
          end
          2'd2: begin   // second division by q
            if (qn_r >= q_r) begin
              qn_r   <= qn_r - q_r;
              qcnt_r <= qcnt_r + IW'(1);
            end else if (qn_r == '0) begin
              mzero_r <= 1'b1;
              mph_r   <= 2'd3;
            end else begin
              sign_r <= ~sign_r;
              q_r    <= q_r + IW'(1);
              qn_r   <= n_r;
              qcnt_r <= '0;
              mph_r  <= 2'd1;
            end
          end
          default: ;
        endcase
        if (mph_r == 2'd1 && qn_r < q_r && qn_r != '0 &&
            (2*IW)'(q_r) * (2*IW)'(q_r) > (2*IW)'(n_r)) begin
          if (n_r > IW'(1)) sign_r <= ~sign_r;
          mph_r <= 2'd3;
        end
      end
      OP_ADD:   acc_r <= acc_r + term;
      OP_NEXTD: d_r <= d_r + IW'(1);
      OP_QSTART: begin
        qneg_r <= acc_r[DimW-1];
        qq_r   <= acc_r[DimW-1] ? word_t'(0) - word_t'(acc_r) : word_t'(acc_r);
        qrem_r <= '0;
        qc_r   <= '0;
      end
      OP_QSTEP: begin
        if (!qtry[IW]) begin
          qrem_r <= {1'b0, qtry[IW-1:0]};
          qq_r   <= {qq_r[DimW-2:0], 1'b1};
        end else begin
          qrem_r <= {qrem_r[IW-1:0], qq_r[DimW-1]};
          qq_r   <= {qq_r[DimW-2:0], 1'b0};
        end
        qc_r <= qc_r + 7'd1;
      end
      OP_QDONE: begin
        total_r <= total_r + (qneg_r ? word_t'(0) - qq_r : qq_r);
        i_r     <= i_r + IW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    sts = '0;
    sts.zero_in  = (dim_r == '0) || (deg_r == '0);
    sts.lvl_done = i_r > deg_r;
    sts.d_done   = d_r > i_r;
    sts.div_busy = rem_r >= d_r;
    sts.divides  = rem_r == '0;
    sts.e_zero   = e_r == '0;
    sts.e_odd    = e_r[0];
    sts.mul_busy = mcnt_r != 2'd3;
    sts.mul_ovf  = mprod_r < pacc_r;
    sts.sqr_ovf  = mprod_r < base_r;
    sts.mob_busy = mph_r != 2'd3;
    sts.add_ovf  = (sum_w[DimW] != sum_w[DimW-1]);
    sts.q_busy   = qc_r != 7'd64;
  end

  assign total = total_r;

endmodule

// ===== rtl/lsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsw_ctrl
// Sequencer over levels, divisors, square-and-multiply, trial division and divide.
// ----------------------------------------------------------------------------
module lsw_ctrl
  import lsw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     res_valid,
  output logic     res_ovf,
  output logic     res_zero,
  input  logic     out_ready,
  input  lsw_sts_t sts,
  output lsw_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_LVL  = 4'd2;
  localparam logic [3:0] S_D    = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_POW  = 4'd5;
  localparam logic [3:0] S_SQR  = 4'd6;
  localparam logic [3:0] S_MOB  = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_QST  = 4'd9;
  localparam logic [3:0] S_Q    = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;
  localparam logic [3:0] S_MOB0 = 4'd12;
  localparam logic [3:0] S_MW   = 4'd13;
  localparam logic [3:0] S_SW   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       ovf_r, ovf_nxt, zero_r, zero_nxt;

  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    zero_nxt  = zero_r;
    cmd.op    = OP_NOP;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LOAD; state_nxt = S_CHK; ovf_nxt = 1'b0; zero_nxt = 1'b0;
      end
      S_CHK: if (sts.zero_in) begin
        zero_nxt = 1'b1; state_nxt = S_OUT;
      end else state_nxt = S_LVL;
      S_LVL: if (sts.lvl_done) state_nxt = S_OUT;
      else begin
        cmd.op = OP_LVL; state_nxt = S_D;
      end
      S_D: if (sts.d_done) begin
        cmd.op = OP_QSTART; state_nxt = S_Q;
      end else begin
        cmd.op = OP_DIVCHK; state_nxt = S_DIV;
      end
      S_DIV: if (sts.div_busy) cmd.op = OP_POWINIT;
      else if (!sts.divides) begin
        cmd.op = OP_NEXTD; state_nxt = S_D;
      end else begin
        cmd.op = OP_POWINIT; state_nxt = S_POW;
      end
      S_POW: if (sts.e_zero) begin
        cmd.op = OP_MOBINIT; state_nxt = S_MOB;
      end else if (sts.e_odd) begin
        cmd.op = OP_MULST; state_nxt = S_MW;
      end else state_nxt = S_SQR;
      S_MW: if (sts.mul_busy) state_nxt = S_MW;
      else if (sts.mul_ovf) begin
        ovf_nxt = 1'b1; state_nxt = S_OUT;
      end else begin
        cmd.op = OP_MULT; state_nxt = S_SQR;
      end
      S_SQR: begin
        cmd.op = OP_SQRST; state_nxt = S_SW;
      end
      S_SW: if (sts.mul_busy) state_nxt = S_SW;
      else if (sts.sqr_ovf) begin
        ovf_nxt = 1'b1; state_nxt = S_OUT;
      end else begin
        cmd.op = OP_SQR; state_nxt = S_POW;
      end
      S_MOB: if (sts.mob_busy) cmd.op = OP_MOBSTEP;
      else state_nxt = S_ADD;
      S_ADD: if (sts.add_ovf) begin
        ovf_nxt = 1'b1; state_nxt = S_OUT;
      end else begin
        cmd.op = OP_ADD; state_nxt = S_MOB0;
      end
      S_MOB0: begin
        cmd.op = OP_NEXTD; state_nxt = S_D;
      end
      S_Q: if (sts.q_busy) cmd.op = OP_QSTEP;
      else begin
        cmd.op = OP_QDONE; state_nxt = S_LVL;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovf_r   <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
      zero_r  <= zero_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign res_valid = state_r == S_OUT;
  assign res_ovf   = ovf_r;
  assign res_zero  = zero_r | ovf_r;

`ifndef SYNTH
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && res_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !out_ready |=> res_valid) else $error("result dropped");
  a_ovfz: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ovf |-> res_zero) else $error("overflow without zero");
`endif

endmodule

// ===== rtl/log_signature_length_witt.sv =====
// ----------------------------------------------------------------------------
// log_signature_length_witt
// Summed Witt necklace count over levels 1..degree.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_      in   dimension[63:0], depth_level[6:0]
// out_     out  length[63:0], overflowed
// One query at a time; in_ready is high only when idle.
// The time a query takes is set by subtractive i mod d and trial division,
// square-and-multiply on a 32x32 multiplier, and the 64-step level divide.
// An overflow or a zero input ends the query early.
// Synchronous active-low reset returns to idle; the result holds until taken.
// ----------------------------------------------------------------------------
module log_signature_length_witt
  import lsw_pkg::*;
#(
  parameter int unsigned MAX_DEGREE = 64
) (
  input logic    clk,
  input logic    rst_n,
  lsw_in_if.sink     in_ch,
  lsw_out_if.source  out_ch
);

  lsw_cmd_t cmd;
  lsw_sts_t sts;
  word_t    total;
  logic     res_zero, res_ovf;

  lsw_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .res_valid(out_ch.valid), .res_ovf(res_ovf), .res_zero(res_zero),
    .out_ready(out_ch.ready), .sts, .cmd
  );

  lsw_datapath #(.MAX_DEGREE(MAX_DEGREE)) u_dp (
    .clk, .cmd, .dimension(in_ch.dimension), .depth_level(in_ch.depth_level),
    .sts, .total
  );

  assign out_ch.length     = res_zero ? '0 : total;
  assign out_ch.overflowed = res_ovf;

endmodule

// ===== tb/lsw_checker.sv =====
// ----------------------------------------------------------------------------
// lsw_checker
// Watches the query and result channels of the Witt necklace length block,
// computes the expected necklace sum for every accepted query and compares
// each accepted result, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module lsw_checker
  import lsw_pkg::*;
#(
  parameter int unsigned MAX_DEGREE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  lsw_in_if           in_ch,
  lsw_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    word_t length;
    logic  overflowed;
  } witt_res_t;

  witt_res_t expected_q[$];

  function automatic word_t wrap_pow(word_t base, int unsigned e, ref bit ovf);
    word_t acc;
    word_t t;
    acc = 64'd1;
    while (e > 0) begin
      if (e[0]) begin
        t = acc * base;
        if (t < acc) begin
          ovf = 1'b1;
          return '0;
        end
        acc = t;
      end
      t = base * base;
      if (t < base) begin
        ovf = 1'b1;
        return '0;
      end
      base = t;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic int mobius(int unsigned n);
    int          sign;
    int unsigned q;
    sign = 1;
    if (n == 0) return 0;
    for (q = 2; q * q <= n; q++) begin
      if (n % q == 0) begin
        n = n / q;
        if (n % q == 0) return 0;
        sign = -sign;
      end
    end
    if (n > 1) sign = -sign;
    return sign;
  endfunction

  function automatic witt_res_t necklace_sum(word_t dim, deg_t deg_in);
    witt_res_t   r;
    int unsigned deg;
    word_t       total;
    word_t       p;
    longint      acc;
    longint      term;
    longint      lmax;
    longint      lmin;
    bit          ovf;
    int          m;
    lmax = 64'sh7FFF_FFFF_FFFF_FFFF;
    lmin = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
    r.length = '0;
    r.overflowed = 1'b0;
    deg = deg_in;
    if (deg > MAX_DEGREE) deg = MAX_DEGREE;
    if (dim == 0 || deg == 0) return r;
    total = '0;
    ovf = 1'b0;
    for (int unsigned i = 1; i <= deg; i++) begin
      acc = 0;
      for (int unsigned d = 1; d <= i; d++) begin
        if (i % d != 0) continue;
        p = wrap_pow(dim, d, ovf);
        if (ovf) begin
          r.overflowed = 1'b1;
          return r;
        end
        m = mobius(i / d);
        term = 0;
        if (m == 1) term = $signed(p);
        else if (m == -1) term = $signed(64'd0 - p);
        if ((term > 0 && acc > lmax - term) || (term < 0 && acc < lmin - term)) begin
          r.overflowed = 1'b1;
          return r;
        end
        acc = acc + term;
      end
      total = total + word_t'(acc / longint'(i));
    end
    r.length = total;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    witt_res_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_q.insert(expected_q.size(),
                          necklace_sum(in_ch.dimension, in_ch.depth_level));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: length %0h overflowed %0b",
                 out_ch.length, out_ch.overflowed);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.length !== e.length || out_ch.overflowed !== e.overflowed) begin
            if (out_ch.length !== e.length)
              $error("length: expected %0h actual %0h", e.length, out_ch.length);
            if (out_ch.overflowed !== e.overflowed)
              $error("overflowed: expected %0b actual %0b", e.overflowed,
                     out_ch.overflowed);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives necklace-length queries into the block with random gaps and result
// back-pressure, and reports the verdict from checker fail and pending counts.
// ----------------------------------------------------------------------------
module tb_top
  import lsw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  bit          stim_done;

  lsw_in_if  in_if();
  lsw_out_if out_if();

  log_signature_length_witt #(.MAX_DEGREE(64)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  lsw_checker #(.MAX_DEGREE(64)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  task automatic send_query(word_t dim, deg_t deg);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_if.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.dimension   = dim;
    in_if.depth_level = deg;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  function automatic word_t rand_dim();
    int unsigned r;
    word_t       w;
    r = $urandom_range(0, 99);
    w = {$urandom(), $urandom()};
    if (r < 55) return word_t'($urandom_range(1, 20));
    if (r < 60) return 0;
    if (r < 80) return w >> $urandom_range(32, 63);
    return w >> $urandom_range(0, 31);
  endfunction

  function automatic deg_t rand_deg();
    if ($urandom_range(0, 9) < 8) return deg_t'($urandom_range(0, 16));
    return deg_t'($urandom_range(0, 127));
  endfunction

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_if.ready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end else if ($urandom_range(0, 1) == 0) begin
        out_if.ready = 1'b1;
        repeat ($urandom_range(0, 200)) @(negedge clk);
      end
      out_if.ready = 1'b1;
    end
  end

  initial begin
    #500ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned w;
    in_if.valid       = 1'b0;
    in_if.dimension   = '0;
    in_if.depth_level = '0;
    stim_done         = 1'b0;
    rst_n             = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_query(64'd0, 7'd0);
    send_query(64'd0, 7'd64);
    send_query(64'd5, 7'd0);
    send_query(64'd1, 7'd64);
    send_query(64'd1, 7'd127);
    send_query(64'd2, 7'd1);
    send_query(64'd2, 7'd10);
    send_query(64'd2, 7'd31);
    send_query(64'd2, 7'd32);
    send_query(64'd2, 7'd64);
    send_query(64'd2, 7'd65);
    send_query(64'd3, 7'd39);
    send_query(64'd3, 7'd40);
    send_query(64'd3, 7'd41);
    send_query(64'hFFFF_FFFF, 7'd1);
    send_query(64'hFFFF_FFFF, 7'd2);
    send_query(64'h1_0000_0000, 7'd1);
    send_query(64'hFFFF_FFFF_FFFF_FFFF, 7'd1);
    send_query(64'hFFFF_FFFF_FFFF_FFFF, 7'd127);
    send_query(64'h8000_0000_0000_0000, 7'd3);
    send_query(64'h7FFF_FFFF, 7'd2);
    send_query(64'h5555_5555_5555_5555, 7'd85);
    send_query(64'hAAAA_AAAA_AAAA_AAAA, 7'd42);
    send_query(64'd16, 7'd15);

    for (int n = 0; n < 300; n++)
      send_query(rand_dim(), rand_deg());
    in_if.valid = 1'b0;

    w = 0;
    while (pending != 0 && w < 2000000) begin
      @(negedge clk);
      w++;
    end
    repeat (5000) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
